// ----- rtl/core/mixed_radix_index_codec_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the mixed radix index codec
// Shared property shapes for same-cycle and next-cycle implications.
// ---------------------------------------------------------------------------
`ifndef MIXED_RADIX_INDEX_CODEC_TOP_DEFINES_SVH
`define MIXED_RADIX_INDEX_CODEC_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define MRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mrc_pkg.sv -----
// ---------------------------------------------------------------------------
// mrc_pkg
// Types and constants shared by the mixed radix index codec.
// ---------------------------------------------------------------------------
package mrc_pkg;

  localparam int DEF_SIZE_WIDTH = 16;
  localparam int FIELD_W        = 16;
  localparam int NUM_W          = 32;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] dim_size;
    logic [FIELD_W-1:0] dim_index;
    logic               dim_wildcard;
    logic [NUM_W-1:0]   start_number;
    logic               first_dim;
    logic               last_dim;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]   packed_number;
    logic [FIELD_W-1:0] index_out;
    logic               wildcard_out;
    logic               is_last;
  } out_item_t;

  // request type codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } ctl_state_t;

  // engine command
  typedef struct packed {
    logic start;
    logic decode;
  } eng_ctl_t;

  // engine status
  typedef struct packed {
    logic busy;
    logic done;
  } eng_sts_t;

endpackage

// ----- rtl/core/mrc_serial_engine.sv -----
// ---------------------------------------------------------------------------
// mrc_serial_engine
// Bit-serial multiply-add (encode) and restoring divide (decode) unit.
// ---------------------------------------------------------------------------
module mrc_serial_engine #(
  parameter int SIZE_WIDTH = mrc_pkg::DEF_SIZE_WIDTH,
  parameter int EFF_W      = (SIZE_WIDTH < mrc_pkg::FIELD_W) ? SIZE_WIDTH : mrc_pkg::FIELD_W,
  parameter int RW         = EFF_W + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mrc_pkg::eng_ctl_t       ctl,
  input  logic [RW-1:0]           radix,
  input  logic [mrc_pkg::NUM_W-1:0] acc_in,
  input  logic [EFF_W-1:0]        digit,
  output mrc_pkg::eng_sts_t       sts,
  output logic [mrc_pkg::NUM_W-1:0] product,
  output logic [mrc_pkg::NUM_W-1:0] quotient,
  output logic [RW-1:0]           remainder
);
  import mrc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             dec_r, dec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] a_r, a_nxt;      // multiplicand, or dividend/quotient shifter
  logic [NUM_W-1:0] p_r, p_nxt;      // product
  logic [RW-1:0]    mpl_r, mpl_nxt;  // multiplier, MSB first
  logic [RW-1:0]    rad_r, rad_nxt;  // divisor
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [EFF_W-1:0] dig_r, dig_nxt;

  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, a_r[NUM_W-1]};
    diff  = trial - {1'b0, rad_r};
    fits  = (trial >= {1'b0, rad_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dec_nxt  = dec_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    p_nxt    = p_r;
    mpl_nxt  = mpl_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    dig_nxt  = dig_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      dec_nxt  = ctl.decode;
      cnt_nxt  = '0;
      a_nxt    = acc_in;
      p_nxt    = '0;
      mpl_nxt  = radix;
      rad_nxt  = radix;
      rem_nxt  = '0;
      dig_nxt  = digit;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (dec_r) begin
        // one quotient bit per cycle
        rem_nxt = fits ? diff[RW-1:0] : trial[RW-1:0];
        a_nxt   = {a_r[NUM_W-2:0], fits};
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else if (cnt_r == CNT_W'(RW)) begin
        // closing step adds the digit
        p_nxt    = p_r + NUM_W'(dig_r);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        p_nxt   = {p_r[NUM_W-2:0], 1'b0} + (mpl_r[RW-1] ? a_r : '0);
        mpl_nxt = {mpl_r[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dec_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dec_r  <= dec_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    p_r   <= p_nxt;
    mpl_r <= mpl_nxt;
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    dig_r <= dig_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign product   = p_r;
  assign quotient  = a_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/mixed_radix_index_codec_top.sv -----
// ---------------------------------------------------------------------------
// mixed_radix_index_codec_top
// Packs a wildcard-capable multi-dimensional index into one element number
// and unpacks it again, one dimension per input transfer.
// ---------------------------------------------------------------------------
// Usage: one dimension per input transfer. A dimension of size S is a digit
// of radix S+1; digit S means "all elements". Encode (req_type 0) takes
// dimensions first to last and folds acc = acc*(S+1) + digit mod 2^32, giving
// one result on the item marked last_dim. Decode (req_type 1) takes
// dimensions last to first, loads start_number on first_dim, and gives one
// result per item: remainder as index (0 plus wildcard_out when it equals S),
// quotient kept for the next item. Items are processed one at a time by a
// bit-serial engine: encode runs one step per radix bit and a closing step
// that adds the digit, decode one step per bit of the 32-bit number in the
// restoring divider; the engine then hands its result to the control FSM.
// The FSM returns to idle as it registers a result and can then accept the
// next item, so a pending result in the output register does not hold up
// the input side unless a second result is ready before the first is taken.
// ---------------------------------------------------------------------------
`include "mixed_radix_index_codec_top_defines.svh"

module mixed_radix_index_codec_top #(
  parameter int SIZE_WIDTH = mrc_pkg::DEF_SIZE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mrc_pkg::out_item_t out_data
);
  import mrc_pkg::*;

  // size and index fields are used to SIZE_WIDTH bits, capped by the field width
  localparam int EFF_W = (SIZE_WIDTH < FIELD_W) ? SIZE_WIDTH : FIELD_W;
  localparam int RW    = EFF_W + 1;

  ctl_state_t        state_r, state_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;      // shared accumulator
  logic              cur_dec_r, cur_dec_nxt;
  logic              cur_last_r, cur_last_nxt;
  logic [EFF_W-1:0]  cur_size_r, cur_size_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              in_xfer;
  logic              out_free;
  logic              emit_ok;
  logic [EFF_W-1:0]  size_eff;
  logic [EFF_W-1:0]  digit;
  logic [RW-1:0]     radix;
  logic [NUM_W-1:0]  base_acc;
  logic              rem_wild;
  out_item_t         result;

  eng_ctl_t          eng_ctl;
  eng_sts_t          eng_sts;
  logic [NUM_W-1:0]  eng_prod;
  logic [NUM_W-1:0]  eng_quot;
  logic [RW-1:0]     eng_rem;

  // ---- input side: operand setup for the engine ----
  assign in_xfer  = in_valid && !in_stall;
  assign size_eff = in_data.dim_size[EFF_W-1:0];
  assign digit    = in_data.dim_wildcard ? size_eff : in_data.dim_index[EFF_W-1:0];
  assign radix    = RW'(size_eff) + 1'b1;

  always_comb begin
    if (in_data.first_dim) begin
      base_acc = (in_data.req_type == REQ_DECODE) ? in_data.start_number : '0;
    end else begin
      base_acc = acc_r;
    end
  end

  mrc_serial_engine #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (eng_ctl),
    .radix     (radix),
    .acc_in    (base_acc),
    .digit     (digit),
    .sts       (eng_sts),
    .product   (eng_prod),
    .quotient  (eng_quot),
    .remainder (eng_rem)
  );

  // ---- result formatting; engine outputs hold after done ----
  assign rem_wild = (eng_rem == RW'(cur_size_r));

  always_comb begin
    if (cur_dec_r) begin
      result.packed_number = '0;
      result.index_out     = rem_wild ? '0 : FIELD_W'(eng_rem);
      result.wildcard_out  = rem_wild;
      result.is_last       = cur_last_r;
    end else begin
      result.packed_number = eng_prod;
      result.index_out     = '0;
      result.wildcard_out  = 1'b0;
      result.is_last       = 1'b1;
    end
  end

  // ---- control FSM: next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (eng_sts.done) begin
          state_nxt = (cur_dec_r || cur_last_r) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- control FSM: outputs ----
  always_comb begin
    in_stall        = 1'b1;
    eng_ctl.start   = 1'b0;
    eng_ctl.decode  = in_data.req_type;
    emit_ok         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        eng_ctl.start = in_valid;
      end
      ST_RUN:  ;
      ST_EMIT: emit_ok = out_free;
      default: ;
    endcase
  end

  // ---- datapath registers ----
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    acc_nxt       = acc_r;
    cur_dec_nxt   = cur_dec_r;
    cur_last_nxt  = cur_last_r;
    cur_size_nxt  = cur_size_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (in_xfer) begin
      cur_dec_nxt  = (in_data.req_type == REQ_DECODE);
      cur_last_nxt = in_data.last_dim;
      cur_size_nxt = size_eff;
    end
    if (state_r == ST_RUN && eng_sts.done) begin
      acc_nxt = cur_dec_r ? eng_quot : eng_prod;
    end
    if (emit_ok) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_dec_r  <= cur_dec_nxt;
    cur_last_r <= cur_last_nxt;
    cur_size_r <= cur_size_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- checks ----
  `MRC_ASSERT_NEXT(a_accept_starts, in_xfer, state_r == ST_RUN && eng_sts.busy, "no engine start")
  `MRC_ASSERT_NOW(a_done_in_run, eng_sts.done, state_r == ST_RUN, "done outside run")
  `MRC_ASSERT_NOW(a_idle_quiet, state_r == ST_IDLE, !eng_sts.busy && !eng_sts.done, "busy in idle")

endmodule

// ----- verif/mixed_radix_index_codec_top_tb.sv -----
// ---------------------------------------------------------------------------
// mixed_radix_index_codec_top_tb
// Self-checking bench for the mixed radix codec. A queue-fed driver pushes
// encode and decode dimension transfers with random gaps. A predictor keeps
// its own accumulator and computes the expected result of every accepted
// transfer. The monitor checks each result field by field, in order. The
// sink side stalls in random bursts.
// ---------------------------------------------------------------------------
module mixed_radix_index_codec_top_tb;
  import mrc_pkg::*;

  localparam int          SIZE_W       = DEF_SIZE_WIDTH;
  localparam logic [63:0] SIZE_MASK    = (64'd1 << SIZE_W) - 64'd1;
  localparam int          RANDOM_ITEMS = 500;
  localparam int          CALM_TAIL    = 60;    // last items run without idling
  localparam int          DRAIN_CYCLES = 40;
  localparam int          QUIET_LIMIT  = 2000;  // cycles without any transfer
  localparam int          MAX_REPORTS  = 10;

  // one pending transfer; hold_off makes the driver wait for all results first
  typedef struct {
    in_item_t payload;
    bit       hold_off;
  } stim_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  stim_t       stim_q[$];
  out_item_t   pending_results[$];
  logic [31:0] number_acc     = '0;  // predictor copy of the shared accumulator
  int          mismatch_count = 0;
  int          accepted_items = 0;
  int          total_items    = 0;
  int          quiet_cycles   = 0;

  // idling state of the two sides
  int in_gap    = 0;
  int in_pct    = 0;
  int in_phase  = 0;
  int out_gap   = 0;
  int out_pct   = 0;
  int out_phase = 0;

  mixed_radix_index_codec_top #(
    .SIZE_WIDTH(SIZE_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected result of one dimension transfer. Encode folds the digit into
  // the accumulator and only answers on the last dimension; decode peels off
  // one digit per transfer and always answers.
  function automatic bit predict_result(input in_item_t it, output out_item_t res);
    logic [63:0] sz, idx, radix, acc, rem;
    sz    = 64'(it.dim_size) & SIZE_MASK;
    idx   = 64'(it.dim_index) & SIZE_MASK;
    radix = sz + 64'd1;
    res   = '0;
    if (it.req_type == REQ_ENCODE) begin
      acc        = it.first_dim ? 64'd0 : 64'(number_acc);
      acc        = acc * radix + (it.dim_wildcard ? sz : idx);
      number_acc = acc[31:0];
      if (!it.last_dim) return 1'b0;
      res.packed_number = acc[31:0];
      res.is_last       = 1'b1;
      return 1'b1;
    end
    acc              = it.first_dim ? 64'(it.start_number) : 64'(number_acc);
    rem              = acc % radix;
    number_acc       = 32'(acc / radix);
    // a zero-sized dimension has radix 1, so remainder 0 reads as wildcard
    res.wildcard_out = (rem == sz);
    res.index_out    = res.wildcard_out ? '0 : rem[FIELD_W-1:0];
    res.is_last      = it.last_dim;
    return 1'b1;
  endfunction

  function automatic in_item_t make_item(logic req, int unsigned sz, int unsigned idx,
                                         logic wc, logic [31:0] num, logic fst, logic lst);
    in_item_t it;
    it.req_type     = req;
    it.dim_size     = sz[FIELD_W-1:0];
    it.dim_index    = idx[FIELD_W-1:0];
    it.dim_wildcard = wc;
    it.start_number = num;
    it.first_dim    = fst;
    it.last_dim     = lst;
    return it;
  endfunction

  task automatic add_item(in_item_t it, bit hold);
    stim_t s;
    s.payload  = it;
    s.hold_off = hold;
    stim_q.push_back(s);
  endtask

  // Stimulus, reset and end of run.
  initial begin : stimulus
    in_item_t    it;
    logic [95:0] noise;
    logic        req;
    logic        wc;
    int unsigned sz;
    int unsigned idx;
    int          n_dims;
    int          made;
    bit          hold;

    // Directed: encode without a leading first flag continues from zero.
    add_item(make_item(REQ_ENCODE, 7, 3, 1'b0, 32'h0, 1'b0, 1'b1), 1'b0);
    // Largest size and index, wildcard at full size, zero size, index over size.
    add_item(make_item(REQ_ENCODE, 65535, 65535, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0), 1'b0);
    add_item(make_item(REQ_ENCODE, 65535, 0, 1'b1, 32'h0, 1'b0, 1'b0), 1'b0);
    add_item(make_item(REQ_ENCODE, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0), 1'b0);
    add_item(make_item(REQ_ENCODE, 10, 40000, 1'b0, 32'h0, 1'b0, 1'b1), 1'b0);
    // Index equal to size packs the same as the wildcard.
    add_item(make_item(REQ_ENCODE, 5, 5, 1'b0, 32'h0, 1'b1, 1'b1), 1'b0);
    add_item(make_item(REQ_ENCODE, 5, 0, 1'b1, 32'h0, 1'b1, 1'b1), 1'b0);
    // Decode from the top number, through a zero-sized dimension.
    add_item(make_item(REQ_DECODE, 65535, 65535, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0), 1'b0);
    add_item(make_item(REQ_DECODE, 65535, 0, 1'b0, 32'h0, 1'b0, 1'b0), 1'b0);
    add_item(make_item(REQ_DECODE, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0), 1'b0);
    add_item(make_item(REQ_DECODE, 1, 0, 1'b0, 32'h0, 1'b0, 1'b1), 1'b0);
    // Sender holds off until the sink has everything, then decodes zero.
    add_item(make_item(REQ_DECODE, 65535, 0, 1'b0, 32'h0, 1'b1, 1'b0), 1'b1);
    // Decode without a first flag keeps the quotient.
    add_item(make_item(REQ_DECODE, 2, 0, 1'b0, 32'h0, 1'b0, 1'b1), 1'b0);
    // Mode flips inside one conversion share the accumulator.
    add_item(make_item(REQ_ENCODE, 9, 4, 1'b0, 32'h0, 1'b1, 1'b0), 1'b0);
    add_item(make_item(REQ_DECODE, 3, 0, 1'b0, 32'h0, 1'b0, 1'b0), 1'b0);
    add_item(make_item(REQ_ENCODE, 6, 2, 1'b0, 32'h0, 1'b0, 1'b1), 1'b0);
    add_item(make_item(REQ_DECODE, 1, 0, 1'b0, 32'h8000_0000, 1'b1, 1'b1), 1'b0);
    add_item(make_item(REQ_DECODE, 32768, 0, 1'b0, 32'h1234_5678, 1'b1, 1'b1), 1'b0);
    add_item(make_item(REQ_ENCODE, 32768, 65535, 1'b0, 32'hA5A5_5A5A, 1'b1, 1'b1), 1'b0);
    add_item(make_item(REQ_ENCODE, 65535, 65535, 1'b1, 32'h0, 1'b1, 1'b1), 1'b0);

    // Random: mostly well-formed conversions, some raw noise transfers.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        noise = {$urandom, $urandom, $urandom};
        it    = noise[$bits(in_item_t)-1:0];
        add_item(it, 1'b0);
        made++;
      end else begin
        req    = $urandom_range(0, 1) ? REQ_DECODE : REQ_ENCODE;
        n_dims = $urandom_range(1, 6);
        hold   = ($urandom_range(0, 49) == 0);
        for (int d = 0; d < n_dims; d++) begin
          // small sizes dominate; edges and wide sizes show up now and then
          case ($urandom_range(0, 15))
            0:       sz = 0;
            1:       sz = 65535;
            2, 3, 4: sz = $urandom_range(0, 65535);
            default: sz = $urandom_range(1, 20);
          endcase
          if (req == REQ_ENCODE) begin
            wc  = ($urandom_range(0, 4) == 0);
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, sz);
          end else begin
            wc  = ($urandom_range(0, 1) == 1);
            idx = $urandom_range(0, 65535);
          end
          it = make_item(req, sz, idx, wc, $urandom, d == 0, d == n_dims - 1);
          add_item(it, hold && d == 0);
          made++;
        end
      end
    end
    total_items = stim_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items != total_items) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[mixed_radix_index_codec_top] OK");
    end else begin
      $display("[mixed_radix_index_codec_top] ERROR");
    end
    $finish;
  end

  // Input driver: holds the payload while stalled, otherwise inserts idle
  // bursts or loads the next transfer. A hold-off transfer waits until no
  // result is outstanding and no transfer lands on this edge.
  always @(posedge clk) begin : drive_in
    bit nv;
    bit drained;
    if (rst_n && !(in_valid && in_stall)) begin
      in_phase++;
      if (in_phase % 256 == 0) in_pct = $urandom_range(0, 3) * 20;
      drained = (pending_results.size() == 0) && !(in_valid && !in_stall);
      nv      = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (stim_q.size() >= CALM_TAIL && $urandom_range(0, 99) < in_pct) begin
        in_gap = $urandom_range(1, 8) - 1;
      end else if (stim_q.size() != 0 && (!stim_q[0].hold_off || drained)) begin
        in_data <= stim_q[0].payload;
        void'(stim_q.pop_front());
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // Sink stall bursts, off during the tail of the run.
  always @(posedge clk) begin : drive_out
    bit ns;
    if (rst_n) begin
      out_phase++;
      if (out_phase % 256 == 0) out_pct = $urandom_range(0, 3) * 20;
      ns = 1'b0;
      if (out_gap != 0) begin
        out_gap--;
        ns = 1'b1;
      end else if (stim_q.size() >= CALM_TAIL && $urandom_range(0, 99) < out_pct) begin
        out_gap = $urandom_range(1, 8) - 1;
        ns      = 1'b1;
      end
      out_stall <= ns;
    end
  end

  // Every accepted input transfer runs through the predictor.
  always @(posedge clk) begin : watch_in
    out_item_t res;
    if (rst_n && in_valid && !in_stall) begin
      accepted_items++;
      if (predict_result(in_data, res)) pending_results.push_back(res);
    end
  end

  // Accepted results against the oldest expectation.
  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: num=%h idx=%h wc=%b last=%b",
                   out_data.packed_number, out_data.index_out,
                   out_data.wildcard_out, out_data.is_last);
      end else begin
        want = pending_results.pop_front();
        if (out_data.packed_number !== want.packed_number ||
            out_data.index_out     !== want.index_out     ||
            out_data.wildcard_out  !== want.wildcard_out  ||
            out_data.is_last       !== want.is_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("result mismatch: exp num=%h idx=%h wc=%b last=%b, ",
                   want.packed_number, want.index_out, want.wildcard_out, want.is_last);
            $display("got num=%h idx=%h wc=%b last=%b",
                     out_data.packed_number, out_data.index_out,
                     out_data.wildcard_out, out_data.is_last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[mixed_radix_index_codec_top] ERROR");
        $finish;
      end
    end
  end

endmodule
